// ----- rtl/fdb_pkg.sv -----
`timescale 1ns / 1ps

package fdb_pkg;

  localparam int unsigned YEAR_MAX   = 9999;
  localparam int unsigned YEAR_W     = 14;
  localparam int unsigned DAYNUM_W   = 22;
  localparam int unsigned TOD_W      = 17;
  localparam int unsigned DIY_W      = 9;
  localparam int unsigned Q100_MUL   = 5243;
  localparam int unsigned Q100_SHIFT = 19;
  localparam int unsigned Q100_PW    = 27;
  localparam int unsigned Q100_W     = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic load_in;
    logic mul_en;
    logic sum_en;
    logic sel;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  // days in months before the given month, month clamped to 12 by caller (month 0 skipped there)
  function automatic logic [DIY_W-1:0] cum_days(input logic [3:0] mon, input logic leap);
    logic [DIY_W-1:0] base;
    case (mon)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && (mon > 4'd2)) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  function automatic logic [TOD_W-1:0] tod_secs(input logic [4:0] h, input logic [5:0] mi,
                                                 input logic [5:0] s);
    return TOD_W'(h) * TOD_W'(3600) + TOD_W'(mi) * TOD_W'(60) + TOD_W'(s);
  endfunction

  function automatic logic [YEAR_W-1:0] sat_year(input logic [YEAR_W-1:0] y);
    return (y > YEAR_W'(YEAR_MAX)) ? YEAR_W'(YEAR_MAX) : y;
  endfunction

endpackage

// ----- rtl/fdb_ctrl.sv -----
`timescale 1ns / 1ps

module fdb_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fdb_pkg::dp_status_t status_i,
  output fdb_pkg::ctrl_cmd_t  cmd_o
);

  fdb_pkg::state_e state_q, state_d;
  logic sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdb_pkg::ST_IDLE;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      fdb_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = fdb_pkg::ST_MUL;
          sel_d   = 1'b0;
        end
      end
      fdb_pkg::ST_MUL: begin
        state_d = fdb_pkg::ST_SUM;
      end
      fdb_pkg::ST_SUM: begin
        if (sel_q) begin
          state_d = fdb_pkg::ST_DONE;
        end else begin
          state_d = fdb_pkg::ST_MUL;
          sel_d   = 1'b1;
        end
      end
      fdb_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = fdb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fdb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_stall_o = 1'b1;
    case (state_q)
      fdb_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      fdb_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
      end
      fdb_pkg::ST_SUM: begin
        cmd_o.sum_en = 1'b1;
      end
      fdb_pkg::ST_DONE: begin
        cmd_o.load_out = status_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/fdb_dpath.sv -----
`timescale 1ns / 1ps

module fdb_dpath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fdb_pkg::ctrl_cmd_t  cmd_i,
  output fdb_pkg::dp_status_t status_o,
  input  logic [13:0]         first_year_i,
  input  logic [3:0]          first_month_i,
  input  logic [4:0]          first_day_i,
  input  logic [4:0]          first_hour_i,
  input  logic [5:0]          first_minute_i,
  input  logic [5:0]          first_second_i,
  input  logic [13:0]         second_year_i,
  input  logic [3:0]          second_month_i,
  input  logic [4:0]          second_day_i,
  input  logic [4:0]          second_hour_i,
  input  logic [5:0]          second_minute_i,
  input  logic [5:0]          second_second_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [21:0]         full_days_o,
  output logic                order_error_o
);

  localparam int unsigned YW = fdb_pkg::YEAR_W;
  localparam int unsigned DW = fdb_pkg::DAYNUM_W;
  localparam int unsigned TW = fdb_pkg::TOD_W;
  localparam int unsigned QW = fdb_pkg::Q100_W;
  localparam int unsigned PW = fdb_pkg::Q100_PW;
  localparam int unsigned SH = fdb_pkg::Q100_SHIFT;

  logic [YW-1:0] yr_q [2];
  logic [3:0]    mon_q [2];
  logic [4:0]    day_q [2];
  logic [TW-1:0] tod_q [2];
  logic [DW-1:0] dn_q [2];

  logic [DW-1:0] base_q, base_d;
  logic [YW-3:0] n4_q, n4_d;
  logic [QW-1:0] qn_q, qn_d;
  logic [QW-1:0] qy_q, qy_d;

  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] full_days_q, full_days_d;
  logic          order_error_q, order_error_d;

  logic [YW-1:0] ysel, nsel;
  logic [PW-1:0] prod_n, prod_y;
  logic [3:0]    msel, mclamp;
  logic          century, leap;
  logic [fdb_pkg::DIY_W-1:0] diy;
  logic [DW-1:0] dn_d;
  logic          late;
  logic [DW:0]   diff;

  // multiply step: 365*y and reciprocal quotients by 100
  always_comb begin
    ysel   = yr_q[cmd_i.sel];
    nsel   = ysel - YW'(1);
    prod_n = PW'(nsel) * PW'(fdb_pkg::Q100_MUL);
    prod_y = PW'(ysel) * PW'(fdb_pkg::Q100_MUL);
    base_d = DW'(ysel) * DW'(365);
    n4_d   = nsel[YW-1:2];
    qn_d   = prod_n[SH+QW-1:SH];
    qy_d   = prod_y[SH+QW-1:SH];
  end

  // sum step: leap rule, day of year and day number
  always_comb begin
    msel    = mon_q[cmd_i.sel];
    mclamp  = (msel > 4'd12) ? 4'd12 : msel;
    century = (ysel == (YW'(qy_q) * YW'(100))) && (qy_q[1:0] != 2'b00);
    leap    = (ysel[1:0] == 2'b00) && !century;
    diy     = (msel == 4'd0) ? '0
            : fdb_pkg::cum_days(mclamp, leap) + fdb_pkg::DIY_W'(day_q[cmd_i.sel]);
    if (ysel == '0) begin
      dn_d = DW'(diy);
    end else begin
      dn_d = base_q + DW'(n4_q) - DW'(qn_q) + DW'(qn_q[QW-1:2]) + DW'(1) + DW'(diy);
    end
  end

  // final difference
  always_comb begin
    late          = tod_q[1] < tod_q[0];
    diff          = {1'b0, dn_q[1]} - {1'b0, dn_q[0]} - (DW+1)'(late);
    order_error_d = diff[DW];
    full_days_d   = diff[DW] ? '0 : diff[DW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      yr_q[0]  <= fdb_pkg::sat_year(first_year_i);
      mon_q[0] <= first_month_i;
      day_q[0] <= first_day_i;
      tod_q[0] <= fdb_pkg::tod_secs(first_hour_i, first_minute_i, first_second_i);
      yr_q[1]  <= fdb_pkg::sat_year(second_year_i);
      mon_q[1] <= second_month_i;
      day_q[1] <= second_day_i;
      tod_q[1] <= fdb_pkg::tod_secs(second_hour_i, second_minute_i, second_second_i);
    end
    if (cmd_i.mul_en) begin
      base_q <= base_d;
      n4_q   <= n4_d;
      qn_q   <= qn_d;
      qy_q   <= qy_d;
    end
    if (cmd_i.sum_en) begin
      dn_q[cmd_i.sel] <= dn_d;
    end
    if (cmd_i.load_out) begin
      full_days_q   <= full_days_d;
      order_error_q <= order_error_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign status_o.out_free = !out_valid_q || !out_stall_i;
  assign out_valid_o       = out_valid_q;
  assign full_days_o       = full_days_q;
  assign order_error_o     = order_error_q;

endmodule

// ----- rtl/full_days_between_timestamps.sv -----
`timescale 1ns / 1ps
// channel   valid        stall         payload
// request   in_valid_i   in_stall_o    first_*_i, second_*_i
// result    out_valid_o  out_stall_i   full_days_o, order_error_o
//
// each request steps through accept, then a multiply and a sum step for each stamp
// on the shared year unit, then the result load into the output register
// a new request is taken while the previous result still waits in the output register
// a stalled result holds the controller in its last step until the register frees
// reset clears the controller state and the output valid flag

module full_days_between_timestamps (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [13:0] first_year_i,
  input  logic [3:0]  first_month_i,
  input  logic [4:0]  first_day_i,
  input  logic [4:0]  first_hour_i,
  input  logic [5:0]  first_minute_i,
  input  logic [5:0]  first_second_i,
  input  logic [13:0] second_year_i,
  input  logic [3:0]  second_month_i,
  input  logic [4:0]  second_day_i,
  input  logic [4:0]  second_hour_i,
  input  logic [5:0]  second_minute_i,
  input  logic [5:0]  second_second_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [21:0] full_days_o,
  output logic        order_error_o
);

  fdb_pkg::ctrl_cmd_t  cmd;
  fdb_pkg::dp_status_t status;

  fdb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fdb_dpath u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .first_year_i    (first_year_i),
    .first_month_i   (first_month_i),
    .first_day_i     (first_day_i),
    .first_hour_i    (first_hour_i),
    .first_minute_i  (first_minute_i),
    .first_second_i  (first_second_i),
    .second_year_i   (second_year_i),
    .second_month_i  (second_month_i),
    .second_day_i    (second_day_i),
    .second_hour_i   (second_hour_i),
    .second_minute_i (second_minute_i),
    .second_second_i (second_second_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .full_days_o     (full_days_o),
    .order_error_o   (order_error_o)
  );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned FULL_DAYS_CAP = 4194303;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } stamp_t;

  typedef struct packed {
    stamp_t from_ts;
    stamp_t to_ts;
  } span_req_t;

  typedef struct packed {
    logic [21:0] full_days;
    logic        order_error;
  } span_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [13:0] first_year_i = '0;
  logic [3:0]  first_month_i = '0;
  logic [4:0]  first_day_i = '0;
  logic [4:0]  first_hour_i = '0;
  logic [5:0]  first_minute_i = '0;
  logic [5:0]  first_second_i = '0;
  logic [13:0] second_year_i = '0;
  logic [3:0]  second_month_i = '0;
  logic [4:0]  second_day_i = '0;
  logic [4:0]  second_hour_i = '0;
  logic [5:0]  second_minute_i = '0;
  logic [5:0]  second_second_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [21:0] full_days_o;
  logic        order_error_o;

  span_result_t expected_spans_q[$];
  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_off_cycles = 0;
  int unsigned  error_count = 0;

  full_days_between_timestamps dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .first_year_i    (first_year_i),
    .first_month_i   (first_month_i),
    .first_day_i     (first_day_i),
    .first_hour_i    (first_hour_i),
    .first_minute_i  (first_minute_i),
    .first_second_i  (first_second_i),
    .second_year_i   (second_year_i),
    .second_month_i  (second_month_i),
    .second_day_i    (second_day_i),
    .second_hour_i   (second_hour_i),
    .second_minute_i (second_minute_i),
    .second_second_i (second_second_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .full_days_o     (full_days_o),
    .order_error_o   (order_error_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit gregorian_leap(int unsigned y);
    return ((y % 4) == 0) && !(((y % 100) == 0) && ((y % 400) != 0));
  endfunction

  function automatic longint day_index(stamp_t s);
    int unsigned month_len[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    int unsigned y;
    int unsigned mon;
    longint      n;
    y = (s.year > fdb_pkg::YEAR_MAX) ? fdb_pkg::YEAR_MAX : s.year;
    n = 0;
    if (y != 0) begin
      n = 365 * longint'(y) + (y - 1) / 4 - (y - 1) / 100 + (y - 1) / 400 + 1;
    end
    if (s.month != 0) begin
      mon = (s.month > 12) ? 12 : s.month;
      for (int m = 0; m + 1 < mon; m++) begin
        n += month_len[m] + ((m == 1 && gregorian_leap(y)) ? 1 : 0);
      end
      n += s.day;
    end
    return n;
  endfunction

  function automatic int unsigned seconds_of_day(stamp_t s);
    return s.hour * 3600 + s.minute * 60 + s.sec;
  endfunction

  function automatic span_result_t predict_full_days(span_req_t r);
    span_result_t res;
    longint       days;
    days = day_index(r.to_ts) - day_index(r.from_ts);
    if (seconds_of_day(r.to_ts) < seconds_of_day(r.from_ts)) begin
      days -= 1;
    end
    if (days < 0) begin
      res.full_days = '0;
      res.order_error = 1'b1;
    end else begin
      if (days > FULL_DAYS_CAP) begin
        days = FULL_DAYS_CAP;
      end
      res.full_days = days[21:0];
      res.order_error = 1'b0;
    end
    return res;
  endfunction

  function automatic stamp_t make_stamp(int unsigned y, int unsigned mo, int unsigned d,
                                        int unsigned h, int unsigned mi, int unsigned s);
    stamp_t t;
    t.year = 14'(y);
    t.month = 4'(mo);
    t.day = 5'(d);
    t.hour = 5'(h);
    t.minute = 6'(mi);
    t.sec = 6'(s);
    return t;
  endfunction

  function automatic stamp_t raw_stamp();
    stamp_t t;
    t = stamp_t'(40'({$urandom, $urandom}));
    return t;
  endfunction

  function automatic stamp_t legal_stamp();
    return make_stamp($urandom_range(0, fdb_pkg::YEAR_MAX), $urandom_range(1, 12),
                      $urandom_range(1, 31), $urandom_range(0, 23), $urandom_range(0, 59),
                      $urandom_range(0, 59));
  endfunction

  function automatic span_req_t random_request();
    span_req_t   r;
    int unsigned kind;
    logic [13:0] y;
    kind = $urandom_range(0, 9);
    r.from_ts = legal_stamp();
    r.to_ts = legal_stamp();
    case (kind)
      0, 1: begin
        r.from_ts = raw_stamp();
        r.to_ts = raw_stamp();
      end
      2: begin
        r.to_ts.year = r.from_ts.year;
      end
      3: begin
        r.to_ts = r.from_ts;
        r.to_ts.day = 5'($urandom_range(r.from_ts.day, 31));
        r.to_ts.hour = 5'($urandom_range(0, 23));
      end
      4, 5: begin
        r.to_ts.year = 14'(r.from_ts.year + $urandom_range(0, 3));
      end
      default: begin
        if (r.to_ts.year < r.from_ts.year) begin
          y = r.to_ts.year;
          r.to_ts.year = r.from_ts.year;
          r.from_ts.year = y;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_request(span_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    first_year_i    <= r.from_ts.year;
    first_month_i   <= r.from_ts.month;
    first_day_i     <= r.from_ts.day;
    first_hour_i    <= r.from_ts.hour;
    first_minute_i  <= r.from_ts.minute;
    first_second_i  <= r.from_ts.sec;
    second_year_i   <= r.to_ts.year;
    second_month_i  <= r.to_ts.month;
    second_day_i    <= r.to_ts.day;
    second_hour_i   <= r.to_ts.hour;
    second_minute_i <= r.to_ts.minute;
    second_second_i <= r.to_ts.sec;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    expected_spans_q.push_back(predict_full_days(r));
  endtask

  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (expected_spans_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // result check and output stall
  always @(posedge clk_i) begin : result_monitor
    span_result_t want;
    if (out_valid_o && !out_stall_i) begin
      if (expected_spans_q.size() == 0) begin
        $error("result with no request pending: full_days %0d order_error %0d",
               full_days_o, order_error_o);
        error_count++;
      end else begin
        want = expected_spans_q.pop_front();
        if (full_days_o !== want.full_days) begin
          $error("full_days expected %0d actual %0d", want.full_days, full_days_o);
          error_count++;
        end
        if (order_error_o !== want.order_error) begin
          $error("order_error expected %0d actual %0d", want.order_error, order_error_o);
          error_count++;
        end
      end
    end
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic test_directed_cases();
    span_req_t r;
    stamp_t    ones;
    stamp_t    zeros;
    ones = '1;
    zeros = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    r = '{make_stamp(2024, 3, 15, 12, 0, 0), make_stamp(2024, 3, 15, 12, 0, 0)};
    send_request(r);
    r.to_ts = make_stamp(2024, 3, 16, 12, 0, 0);
    send_request(r);
    r.to_ts = make_stamp(2024, 3, 16, 11, 59, 59);
    send_request(r);
    // later stamp one second before the earlier one
    r.to_ts = make_stamp(2024, 3, 15, 11, 59, 59);
    send_request(r);
    send_request('{make_stamp(2020, 6, 1, 0, 0, 0), make_stamp(2019, 6, 1, 0, 0, 0)});
    send_request('{make_stamp(0, 1, 1, 0, 0, 0),
                   make_stamp(fdb_pkg::YEAR_MAX, 12, 31, 23, 59, 59)});
    // leap rule across february, and across the end of a century year
    send_request('{make_stamp(0, 2, 28, 0, 0, 0), make_stamp(0, 3, 1, 0, 0, 0)});
    send_request('{make_stamp(1900, 2, 28, 0, 0, 0), make_stamp(1900, 3, 1, 0, 0, 0)});
    send_request('{make_stamp(2000, 2, 28, 0, 0, 0), make_stamp(2000, 3, 1, 0, 0, 0)});
    send_request('{make_stamp(2100, 12, 31, 0, 0, 0), make_stamp(2101, 1, 1, 0, 0, 0)});
    // year saturation
    send_request('{make_stamp(fdb_pkg::YEAR_MAX, 5, 5, 0, 0, 0),
                   make_stamp(16383, 5, 5, 0, 0, 0)});
    send_request('{make_stamp(16383, 1, 1, 0, 0, 0),
                   make_stamp(fdb_pkg::YEAR_MAX, 1, 1, 0, 0, 0)});
    // month zero and month above twelve
    send_request('{make_stamp(2001, 0, 31, 0, 0, 0), make_stamp(2001, 1, 1, 0, 0, 0)});
    send_request('{make_stamp(2001, 12, 1, 0, 0, 0), make_stamp(2001, 15, 1, 0, 0, 0)});
    // unchecked day and time of day
    send_request('{make_stamp(2001, 2, 0, 0, 0, 0), make_stamp(2001, 2, 31, 0, 0, 0)});
    send_request('{make_stamp(2001, 2, 31, 0, 0, 0), make_stamp(2001, 3, 3, 0, 0, 0)});
    send_request('{make_stamp(2001, 1, 1, 31, 63, 63), make_stamp(2001, 1, 3, 0, 0, 0)});
    send_request('{ones, ones});
    send_request('{zeros, zeros});
    send_request('{zeros, ones});
    send_request('{ones, zeros});
    wait_results_done();
  endtask

  task automatic test_output_hold_off();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_cycles = 200;
    repeat (16) send_request(random_request());
    // sender pauses until the block has returned everything
    wait_results_done();
  endtask

  task automatic test_random_traffic(int unsigned tx_idle, int unsigned rx_idle,
                                     int unsigned count);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    repeat (count) send_request(random_request());
    wait_results_done();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_output_hold_off();
    test_random_traffic(31, 67, 250);
    test_random_traffic(67, 31, 250);
    test_random_traffic(0, 0, 250);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
